FILE: rtl/assert_macros.svh
// Assertion macros shared by the motor current supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every rising clock edge outside reset.
`define MCS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: check failed");

// Same-cycle implication.
`define MCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication.
`define MCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`else

`define MCS_ASSERT(lbl, clk, rstn, prop)
`define MCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/mcs_pkg.sv
// Shared types and constants of the motor current supervisor.
package mcs_pkg;

    localparam int WINDOW_LEN = 5;
    localparam int ADC_BITS   = 12;

    localparam int ADC_PORT_W = 12;
    localparam int MA_W       = 12;
    localparam int THR_W      = 13;
    localparam int SPEED_W    = 10;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 17;
    localparam int OFFSET_W   = 10;
    localparam int PERIOD_W   = 16;
    localparam int PHASE_W    = 16;
    localparam int TIMEOUT_W  = 20;
    localparam int TRIP_W     = 4;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    localparam int PROD_W  = ADC_BITS + GAIN_W;
    localparam int SCALE_W = PROD_W - 16;
    localparam int DIFF_W  = ((SCALE_W > OFFSET_W) ?
                              ((SCALE_W > MA_W) ? SCALE_W : MA_W) :
                              ((OFFSET_W > MA_W) ? OFFSET_W : MA_W)) + 1;
    localparam int SUM_W   = $clog2(WINDOW_LEN * (1 << MA_W));

    // The window average divides by a rounded-up reciprocal of the window length.
    // With one guard bit per bit of the length the quotient is exact for any sum.
    localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_LEN);
    localparam int RECIP_W   = SUM_W + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam logic [ADC_PORT_W-1:0] ADC_MASK = ADC_PORT_W'((64'd1 << ADC_BITS) - 64'd1);
    localparam logic [MA_W-1:0]       MA_MAX   = '1;

    localparam logic [SPEED_W-1:0] SPEED_MAX   = 10'd999;
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 10'd700;
    localparam logic [SPEED_W-1:0] SPEED_STEP  = 10'd100;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd900;

    localparam logic [THR_W-1:0] THR_RESET = 13'd900;
    localparam logic [THR_W-1:0] THR_STOP  = 13'd1000;
    localparam logic [THR_W-1:0] CAL_FLOOR = 13'd100;
    localparam logic [MA_W-1:0]  CAL_LOW   = 12'd50;
    localparam logic [TRIP_W-1:0] TRIP_MAX = '1;

    localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd500;
    localparam logic [GAIN_W-1:0]    GAIN_RESET    = 17'd44809;
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 10'd90;
    localparam logic [TRIP_W-1:0]    TRIP_RESET    = 4'd5;
    localparam logic [PHASE_W-1:0]   STARTUP_RESET = 16'd2000;
    localparam logic [PHASE_W-1:0]   CAL_RESET     = 16'd3000;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd20000;

    typedef enum logic [2:0] {
        CMD_SAMPLE  = 3'd0,
        CMD_FORWARD = 3'd1,
        CMD_REVERSE = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_FASTER  = 3'd4,
        CMD_SLOWER  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_START = 2'd1,
        MODE_CAL   = 2'd2,
        MODE_RUN   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NONE    = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } dir_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD = 3'd0,
        CFG_GAIN          = 3'd1,
        CFG_OFFSET        = 3'd2,
        CFG_TRIP_LIMIT    = 3'd3,
        CFG_STARTUP       = 3'd4,
        CFG_CALIBRATE     = 3'd5,
        CFG_TIMEOUT       = 3'd6
    } cfg_reg_t;

endpackage

FILE: rtl/mcs_avg_window.sv
// Moving-average window of current samples with a running sum.
module mcs_avg_window (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push_i,
    input  logic [mcs_pkg::MA_W-1:0] ma_i,
    output logic [mcs_pkg::MA_W-1:0] avg_o
);

    localparam int LEN = mcs_pkg::WINDOW_LEN;
    localparam int SW  = mcs_pkg::SUM_W;
    localparam int MW  = mcs_pkg::MA_W;
    localparam int PW  = SW + mcs_pkg::RECIP_W;

    logic [MW-1:0] win_reg [LEN];
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_next;
    logic [PW-1:0] avg_prod;

    // The oldest entry leaves the sum as the new one enters it.
    assign sum_next = sum_reg - SW'(win_reg[0]) + SW'(ma_i);
    // Division by the window length as a multiply by its reciprocal and a shift.
    assign avg_prod = PW'(sum_next) * PW'(mcs_pkg::AVG_RECIP);
    assign avg_o    = MW'(avg_prod >> mcs_pkg::AVG_SHIFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int i = 0; i < LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (push_i) begin
            sum_reg <= sum_next;
            for (int i = 0; i < LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[LEN-1] <= ma_i;
        end
    end

endmodule

FILE: rtl/motor_current_supervisor_unit.sv
// Top level of the motor current supervisor: command handling, current scaling and mode control.
//
// This block drives a DC motor from a stream of command beats and watches its current.
// Each input beat carries a command (sample, forward, reverse, stop, faster, slower), the
// present millisecond time and an ADC code, and each one produces exactly one result beat
// with the drive state after the command: whether the beat was a used sample, the motor
// mode, the drive direction, the PWM duty, the five-sample average current, the present
// overcurrent threshold and the time since the last start. A sample is used only while
// the motor is not off and at least sample_period_ms after the previous used sample. A
// used sample is scaled to milliamps (gain in Q16, minus offset, floored at zero and
// saturated at 4095), enters the moving average and steps the mode machine from starting
// to calibrating to running; calibration sets the threshold to 1.5 times the average with
// a 100 mA floor, and a running motor stops after trip_limit consecutive averages above
// the threshold or when its run time passes run_timeout_ms. Stop sets the threshold to
// 1000 mA. A new beat is accepted every clock cycle while the result side does not stall;
// each beat passes the input register (which also holds the gain product) and the result
// register, with all state updated in the single pass between them. The block needs no
// clearing pass after reset. The user must write configuration registers through cfg_wr_en,
// cfg_index and cfg_wdata only while no beat is in flight; the block does not enforce it.
module motor_current_supervisor_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcs_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_command,
    input  logic [mcs_pkg::TIME_W-1:0]     s_now_ms,
    input  logic [mcs_pkg::ADC_PORT_W-1:0] s_adc_code,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_sample_used,
    output logic [1:0]                     m_motor_mode,
    output logic [1:0]                     m_drive_direction,
    output logic [mcs_pkg::SPEED_W-1:0]    m_duty,
    output logic [mcs_pkg::MA_W-1:0]       m_average_ma,
    output logic [mcs_pkg::THR_W-1:0]      m_threshold_ma,
    output logic [mcs_pkg::TIME_W-1:0]     m_elapsed_ms
);

    `include "assert_macros.svh"

    localparam int PW  = mcs_pkg::PROD_W;
    localparam int SCW = mcs_pkg::SCALE_W;
    localparam int DW  = mcs_pkg::DIFF_W;
    localparam int MW  = mcs_pkg::MA_W;
    localparam int TW  = mcs_pkg::TIME_W;
    localparam int THW = mcs_pkg::THR_W;
    localparam int SPW = mcs_pkg::SPEED_W;

    // Configuration registers.
    logic [mcs_pkg::PERIOD_W-1:0]  period_reg;
    logic [mcs_pkg::GAIN_W-1:0]    gain_reg;
    logic [mcs_pkg::OFFSET_W-1:0]  offset_reg;
    logic [mcs_pkg::TRIP_W-1:0]    trip_limit_reg;
    logic [mcs_pkg::PHASE_W-1:0]   startup_reg;
    logic [mcs_pkg::PHASE_W-1:0]   calibrate_reg;
    logic [mcs_pkg::TIMEOUT_W-1:0] timeout_reg;

    // Input register. The gain product is formed on the way in, so the
    // state pass starts from scaled milliamps before the offset.
    logic                in_valid_reg;
    mcs_pkg::cmd_t       cmd_reg;
    logic [TW-1:0]       now_reg;
    logic [SCW-1:0]      scaled_reg;
    logic [mcs_pkg::ADC_PORT_W-1:0] code_masked;
    logic [PW-1:0]       product;

    // Supervisor state.
    mcs_pkg::mode_t      mode_reg,      mode_next;
    mcs_pkg::dir_t       dir_reg,       dir_next;
    logic [SPW-1:0]      speed_reg,     speed_next;
    logic [TW-1:0]       start_reg,     start_next;
    logic [TW-1:0]       last_reg,      last_next;
    logic [TW-1:0]       elapsed_reg,   elapsed_next;
    logic [MW-1:0]       average_reg,   average_next;
    logic [mcs_pkg::TRIP_W-1:0] trip_reg, trip_next;
    logic [THW-1:0]      threshold_reg, threshold_next;

    // Result register.
    logic                m_valid_reg;
    logic                out_used_reg;
    logic [1:0]          out_mode_reg;
    logic [1:0]          out_dir_reg;
    logic [SPW-1:0]      out_duty_reg;
    logic [MW-1:0]       out_avg_reg;
    logic [THW-1:0]      out_thr_reg;
    logic [TW-1:0]       out_elapsed_reg;

    // Handshake between the two registers.
    logic                advance;
    logic                fire;

    // Single-pass datapath.
    logic [DW-1:0]       diff;
    logic [MW-1:0]       ma;
    logic                sample_ok;
    logic                push;
    logic [MW-1:0]       avg_new;
    logic [TW-1:0]       elapsed_new;
    logic [THW-1:0]      cal_thr;
    logic [mcs_pkg::TRIP_W-1:0] trip_inc;
    logic [SPW:0]        speed_up;
    logic [SPW:0]        speed_dn;
    logic                used;

    // The result register frees whenever it is empty or being taken, and the
    // input register refills in the same cycle it hands its beat over.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign fire    = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= mcs_pkg::PERIOD_RESET;
            gain_reg       <= mcs_pkg::GAIN_RESET;
            offset_reg     <= mcs_pkg::OFFSET_RESET;
            trip_limit_reg <= mcs_pkg::TRIP_RESET;
            startup_reg    <= mcs_pkg::STARTUP_RESET;
            calibrate_reg  <= mcs_pkg::CAL_RESET;
            timeout_reg    <= mcs_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mcs_pkg::CFG_SAMPLE_PERIOD: begin
                    period_reg <= cfg_wdata[mcs_pkg::PERIOD_W-1:0];
                end
                mcs_pkg::CFG_GAIN: begin
                    gain_reg <= cfg_wdata[mcs_pkg::GAIN_W-1:0];
                end
                mcs_pkg::CFG_OFFSET: begin
                    offset_reg <= cfg_wdata[mcs_pkg::OFFSET_W-1:0];
                end
                mcs_pkg::CFG_TRIP_LIMIT: begin
                    trip_limit_reg <= cfg_wdata[mcs_pkg::TRIP_W-1:0];
                end
                mcs_pkg::CFG_STARTUP: begin
                    startup_reg <= cfg_wdata[mcs_pkg::PHASE_W-1:0];
                end
                mcs_pkg::CFG_CALIBRATE: begin
                    calibrate_reg <= cfg_wdata[mcs_pkg::PHASE_W-1:0];
                end
                mcs_pkg::CFG_TIMEOUT: begin
                    timeout_reg <= cfg_wdata[mcs_pkg::TIMEOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Only the low ADC_BITS bits of the code carry the conversion.
    assign code_masked = s_adc_code & mcs_pkg::ADC_MASK;
    assign product     = PW'(code_masked) * PW'(gain_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= mcs_pkg::cmd_t'(s_command);
            now_reg    <= s_now_ms;
            scaled_reg <= product[PW-1:16];
        end
    end

    // Offset removal: a negative or zero difference reads as zero milliamps,
    // and anything above the 12-bit range saturates.
    assign diff = DW'(scaled_reg) - DW'(offset_reg);
    always_comb begin
        if (diff[DW-1]) begin
            ma = '0;
        end else if (diff > DW'(mcs_pkg::MA_MAX)) begin
            ma = mcs_pkg::MA_MAX;
        end else begin
            ma = diff[MW-1:0];
        end
    end

    // A sample counts only while the motor is not off and the sample period
    // has passed; the time difference wraps with the millisecond counter.
    assign sample_ok = (cmd_reg == mcs_pkg::CMD_SAMPLE) && (mode_reg != mcs_pkg::MODE_OFF)
                       && ((now_reg - last_reg) >= TW'(period_reg));
    assign used      = sample_ok;
    assign push      = fire && sample_ok;

    mcs_avg_window u_avg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .ma_i    (ma),
        .avg_o   (avg_new)
    );

    assign elapsed_new = now_reg - start_reg;

    // Calibration threshold is 1.5 times the average, with a floor for a
    // lightly loaded motor.
    assign cal_thr  = (avg_new < mcs_pkg::CAL_LOW) ? mcs_pkg::CAL_FLOOR
                    : THW'(avg_new) + THW'(avg_new >> 1);
    assign trip_inc = (trip_reg == mcs_pkg::TRIP_MAX) ? trip_reg : trip_reg + 1'b1;

    assign speed_up = {1'b0, speed_reg} + {1'b0, mcs_pkg::SPEED_STEP};
    assign speed_dn = {1'b0, speed_reg} - {1'b0, mcs_pkg::SPEED_STEP};

    always_comb begin
        mode_next      = mode_reg;
        dir_next       = dir_reg;
        speed_next     = speed_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        elapsed_next   = elapsed_reg;
        average_next   = average_reg;
        trip_next      = trip_reg;
        threshold_next = threshold_reg;

        case (cmd_reg)
            mcs_pkg::CMD_SAMPLE: begin
                if (sample_ok) begin
                    last_next    = now_reg;
                    elapsed_next = elapsed_new;
                    average_next = avg_new;
                    if (mode_reg == mcs_pkg::MODE_START
                        && elapsed_new > TW'(startup_reg)) begin
                        mode_next = mcs_pkg::MODE_CAL;
                    end else if (mode_reg == mcs_pkg::MODE_CAL
                                 && elapsed_new > TW'(calibrate_reg)) begin
                        threshold_next = cal_thr;
                        mode_next      = mcs_pkg::MODE_RUN;
                    end else if (mode_reg == mcs_pkg::MODE_RUN) begin
                        if (THW'(avg_new) > threshold_reg) begin
                            trip_next = trip_inc;
                            if (trip_inc >= trip_limit_reg) begin
                                mode_next      = mcs_pkg::MODE_OFF;
                                dir_next       = mcs_pkg::DIR_NONE;
                                threshold_next = mcs_pkg::THR_STOP;
                            end
                        end else begin
                            trip_next = '0;
                        end
                        // The run timeout is checked even after a trip.
                        if (elapsed_new > TW'(timeout_reg)) begin
                            mode_next      = mcs_pkg::MODE_OFF;
                            dir_next       = mcs_pkg::DIR_NONE;
                            threshold_next = mcs_pkg::THR_STOP;
                        end
                    end
                end
            end
            mcs_pkg::CMD_FORWARD: begin
                dir_next     = mcs_pkg::DIR_FORWARD;
                start_next   = now_reg;
                mode_next    = mcs_pkg::MODE_START;
                trip_next    = '0;
                elapsed_next = '0;
            end
            mcs_pkg::CMD_REVERSE: begin
                // Reverse restarts the motor but keeps the reported run time.
                dir_next   = mcs_pkg::DIR_REVERSE;
                start_next = now_reg;
                mode_next  = mcs_pkg::MODE_START;
                trip_next  = '0;
            end
            mcs_pkg::CMD_STOP: begin
                mode_next      = mcs_pkg::MODE_OFF;
                dir_next       = mcs_pkg::DIR_NONE;
                threshold_next = mcs_pkg::THR_STOP;
            end
            mcs_pkg::CMD_FASTER: begin
                if (speed_up > {1'b0, mcs_pkg::SPEED_MAX}) begin
                    speed_next = mcs_pkg::SPEED_MAX;
                end else begin
                    speed_next = speed_up[SPW-1:0];
                end
            end
            mcs_pkg::CMD_SLOWER: begin
                if (speed_dn[SPW] || speed_dn < {1'b0, mcs_pkg::SPEED_MIN}) begin
                    speed_next = mcs_pkg::SPEED_MIN;
                end else begin
                    speed_next = speed_dn[SPW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= mcs_pkg::MODE_OFF;
            dir_reg       <= mcs_pkg::DIR_NONE;
            speed_reg     <= mcs_pkg::SPEED_RESET;
            start_reg     <= '0;
            last_reg      <= '0;
            elapsed_reg   <= '0;
            average_reg   <= '0;
            trip_reg      <= '0;
            threshold_reg <= mcs_pkg::THR_RESET;
        end else if (fire) begin
            mode_reg      <= mode_next;
            dir_reg       <= dir_next;
            speed_reg     <= speed_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            elapsed_reg   <= elapsed_next;
            average_reg   <= average_next;
            trip_reg      <= trip_next;
            threshold_reg <= threshold_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    // The duty output shows the speed only while a bridge side is driven.
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_used_reg    <= used;
            out_mode_reg    <= mode_next;
            out_dir_reg     <= dir_next;
            out_duty_reg    <= (dir_next != mcs_pkg::DIR_NONE) ? speed_next : '0;
            out_avg_reg     <= average_next;
            out_thr_reg     <= threshold_next;
            out_elapsed_reg <= elapsed_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sample_used     = out_used_reg;
    assign m_motor_mode      = out_mode_reg;
    assign m_drive_direction = out_dir_reg;
    assign m_duty            = out_duty_reg;
    assign m_average_ma      = out_avg_reg;
    assign m_threshold_ma    = out_thr_reg;
    assign m_elapsed_ms      = out_elapsed_reg;

    // The speed never leaves its clamp range.
    `MCS_ASSERT(a_speed_range, aclk, aresetn, speed_reg >= mcs_pkg::SPEED_MIN && speed_reg <= mcs_pkg::SPEED_MAX)
    // The motor is off exactly when no bridge side is driven.
    `MCS_ASSERT(a_mode_dir, aclk, aresetn, (mode_reg == mcs_pkg::MODE_OFF) == (dir_reg == mcs_pkg::DIR_NONE))
    // Leaving calibration installs a threshold no lower than the average it came from.
    `MCS_ASSERT_IMPL(a_cal_thr, aclk, aresetn, mode_reg == mcs_pkg::MODE_RUN && $past(mode_reg) == mcs_pkg::MODE_CAL, threshold_reg >= THW'(average_reg))
    // A held input beat is neither lost nor overwritten while the result side stalls.
    `MCS_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(now_reg) && $stable(scaled_reg))

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the motor current supervisor with a cycle-free drive model.
module tb_top;
    import mcs_pkg::*;

    // Command codes six and seven are not decoded by the block and must pass as no-ops.
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // One input beat: the command, the millisecond time stamp and the ADC code.
    typedef struct packed {
        logic [2:0]            command;
        logic [TIME_W-1:0]     now_ms;
        logic [ADC_PORT_W-1:0] adc_code;
    } motor_cmd_t;

    // One result beat, field for field as the block presents it.
    typedef struct packed {
        logic               sample_used;
        logic [1:0]         motor_mode;
        logic [1:0]         drive_direction;
        logic [SPEED_W-1:0] duty;
        logic [MA_W-1:0]    average_ma;
        logic [THR_W-1:0]   threshold_ma;
        logic [TIME_W-1:0]  elapsed_ms;
    } drive_status_t;

    // Clock, reset and every input of the block start at known values.
    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_command  = '0;
    logic [TIME_W-1:0]     s_now_ms   = '0;
    logic [ADC_PORT_W-1:0] s_adc_code = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic                  m_sample_used;
    logic [1:0]            m_motor_mode;
    logic [1:0]            m_drive_direction;
    logic [SPEED_W-1:0]    m_duty;
    logic [MA_W-1:0]       m_average_ma;
    logic [THR_W-1:0]      m_threshold_ma;
    logic [TIME_W-1:0]     m_elapsed_ms;

    // Beats waiting to be offered, and the drive status each accepted beat must produce.
    motor_cmd_t    cmd_backlog[$];
    drive_status_t status_due[$];

    // Model copy of the configuration registers, at their reset values.
    logic [PERIOD_W-1:0]  cfg_period  = PERIOD_RESET;
    logic [GAIN_W-1:0]    cfg_gain    = GAIN_RESET;
    logic [OFFSET_W-1:0]  cfg_offset  = OFFSET_RESET;
    logic [TRIP_W-1:0]    cfg_trip    = TRIP_RESET;
    logic [PHASE_W-1:0]   cfg_startup = STARTUP_RESET;
    logic [PHASE_W-1:0]   cfg_calib   = CAL_RESET;
    logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_RESET;

    // Model copy of the drive state, at its reset values.
    mode_t              mot_mode       = MODE_OFF;
    dir_t               mot_dir        = DIR_NONE;
    logic [SPEED_W-1:0] mot_speed      = SPEED_RESET;
    logic [TIME_W-1:0]  run_start_ms   = '0;
    logic [TIME_W-1:0]  last_used_ms   = '0;
    logic [TIME_W-1:0]  run_elapsed_ms = '0;
    logic [MA_W-1:0]    ma_window [WINDOW_LEN] = '{default: '0};
    logic [MA_W-1:0]    avg_ma         = '0;
    logic [TRIP_W-1:0]  over_count     = '0;
    logic [THR_W-1:0]   limit_ma       = THR_RESET;

    // Time base of the generated stimulus; it advances like the motor controller's tick.
    logic [TIME_W-1:0] stream_ms = '0;

    int unsigned beats_pushed      = 0;
    int unsigned beats_accepted    = 0;
    int unsigned results_seen      = 0;
    int unsigned used_seen         = 0;
    int unsigned running_seen      = 0;
    int unsigned supervision_stops = 0;
    int unsigned mismatches        = 0;
    int          hold_left         = 0;
    bit          held_once         = 1'b0;

    motor_current_supervisor_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_now_ms          (s_now_ms),
        .s_adc_code        (s_adc_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sample_used     (m_sample_used),
        .m_motor_mode      (m_motor_mode),
        .m_drive_direction (m_drive_direction),
        .m_duty            (m_duty),
        .m_average_ma      (m_average_ma),
        .m_threshold_ma    (m_threshold_ma),
        .m_elapsed_ms      (m_elapsed_ms)
    );

    // 12 ns clock, low half first.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The run is cut off here if the block ever stops moving beats.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // A stop command and a supervision trip both drop the drive the same way.
    function automatic void stop_drive();
        mot_mode = MODE_OFF;
        mot_dir  = DIR_NONE;
        limit_ma = THR_STOP;
    endfunction

    // Speed moves in steps and is held inside the PWM window.
    function automatic logic [SPEED_W-1:0] clamp_duty(int unsigned spd);
        if (spd > SPEED_MAX) spd = SPEED_MAX;
        if (spd > 0 && spd < SPEED_MIN) spd = SPEED_MIN;
        return SPEED_W'(spd);
    endfunction

    // Applies one accepted beat to the model state and returns the status it must produce.
    function automatic drive_status_t advance_drive(motor_cmd_t c);
        drive_status_t   st;
        logic [63:0]     scaled;
        logic [MA_W-1:0] ma;
        int unsigned     sum;
        int              i;
        logic            used;
        used = 1'b0;
        case (c.command)
            CMD_SAMPLE: begin
                // The time test is modulo 2^32, so a wrapped clock still counts forward.
                if (mot_mode != MODE_OFF && TIME_W'(c.now_ms - last_used_ms) >= cfg_period) begin
                    used           = 1'b1;
                    last_used_ms   = c.now_ms;
                    run_elapsed_ms = c.now_ms - run_start_ms;
                    scaled = (64'(c.adc_code & ADC_MASK) * 64'(cfg_gain)) >> 16;
                    if (scaled <= 64'(cfg_offset)) begin
                        ma = '0;
                    end else if (scaled - 64'(cfg_offset) > 64'(MA_MAX)) begin
                        ma = MA_MAX;
                    end else begin
                        ma = MA_W'(scaled - 64'(cfg_offset));
                    end
                    for (i = 0; i < WINDOW_LEN - 1; i++) ma_window[i] = ma_window[i + 1];
                    ma_window[WINDOW_LEN - 1] = ma;
                    sum = 0;
                    for (i = 0; i < WINDOW_LEN; i++) sum += ma_window[i];
                    avg_ma = MA_W'(sum / WINDOW_LEN);
                    if (mot_mode == MODE_START && run_elapsed_ms > cfg_startup) begin
                        mot_mode = MODE_CAL;
                    end else if (mot_mode == MODE_CAL && run_elapsed_ms > cfg_calib) begin
                        // Threshold is half again the average, but never below the floor.
                        limit_ma = (avg_ma < CAL_LOW) ? CAL_FLOOR :
                                   THR_W'((32'(avg_ma) * 3) / 2);
                        mot_mode = MODE_RUN;
                    end else if (mot_mode == MODE_RUN) begin
                        if (avg_ma > limit_ma) begin
                            if (over_count != TRIP_MAX) over_count++;
                            if (over_count >= cfg_trip) stop_drive();
                        end else begin
                            over_count = '0;
                        end
                        // The run timeout is checked even when a trip already stopped it.
                        if (run_elapsed_ms > cfg_timeout) stop_drive();
                        if (mot_mode == MODE_OFF) supervision_stops++;
                    end
                end
            end
            CMD_FORWARD: begin
                mot_dir        = DIR_FORWARD;
                run_start_ms   = c.now_ms;
                mot_mode       = MODE_START;
                over_count     = '0;
                run_elapsed_ms = '0;
            end
            CMD_REVERSE: begin
                // Reverse restarts the run but keeps the last elapsed time on show.
                mot_dir      = DIR_REVERSE;
                run_start_ms = c.now_ms;
                mot_mode     = MODE_START;
                over_count   = '0;
            end
            CMD_STOP:   stop_drive();
            CMD_FASTER: mot_speed = clamp_duty(32'(mot_speed) + 32'(SPEED_STEP));
            CMD_SLOWER: mot_speed = clamp_duty(32'(mot_speed) - 32'(SPEED_STEP));
            default: ;
        endcase
        st.sample_used     = used;
        st.motor_mode      = mot_mode;
        st.drive_direction = mot_dir;
        st.duty            = (mot_dir != DIR_NONE) ? mot_speed : '0;
        st.average_ma      = avg_ma;
        st.threshold_ma    = limit_ma;
        st.elapsed_ms      = run_elapsed_ms;
        return st;
    endfunction

    task automatic compare_field(input string tag, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
            mismatches++;
        end
    endtask

    // Sender. A beat is predicted at the edge that accepts it, so the model sees the
    // beats in exactly the order the block does. Valid is only lowered or reloaded once
    // the beat on the bus has gone, and each edge makes at most one assignment to it.
    always @(posedge aclk) begin : cmd_driver
        motor_cmd_t nxt;
        bit         idle;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                status_due.push_back(advance_drive('{s_command, s_now_ms, s_adc_code}));
                beats_accepted++;
            end
            if (!s_valid || s_ready) begin
                // A stretch of back-to-back beats with no idle cycles at all.
                idle = !(beats_accepted >= 250 && beats_accepted < 330) &&
                       ($urandom_range(0, 99) < 14);
                if (cmd_backlog.size() > 0 && !idle) begin
                    nxt = cmd_backlog.pop_front();
                    s_valid    <= 1'b1;
                    s_command  <= nxt.command;
                    s_now_ms   <= nxt.now_ms;
                    s_adc_code <= nxt.adc_code;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker. Every result beat is held against the oldest prediction.
    // Once, while plenty of beats are still queued, ready is held low while the sender keeps
    // offering, so the pipeline fills and input ready has to drop.
    always @(posedge aclk) begin : status_monitor
        drive_status_t got;
        drive_status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_sample_used, m_motor_mode, m_drive_direction, m_duty,
                        m_average_ma, m_threshold_ma, m_elapsed_ms};
                if (status_due.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    compare_field("sample_used",     want.sample_used,     got.sample_used);
                    compare_field("motor_mode",      want.motor_mode,      got.motor_mode);
                    compare_field("drive_direction", want.drive_direction, got.drive_direction);
                    compare_field("duty",            want.duty,            got.duty);
                    compare_field("average_ma",      want.average_ma,      got.average_ma);
                    compare_field("threshold_ma",    want.threshold_ma,    got.threshold_ma);
                    compare_field("elapsed_ms",      want.elapsed_ms,      got.elapsed_ms);
                end
                results_seen++;
                if (got.sample_used === 1'b1) used_seen++;
                if (got.motor_mode === MODE_RUN) running_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && results_seen >= 120 && cmd_backlog.size() > 10) begin
                held_once = 1'b1;
                hold_left = 79;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (results_seen >= 300 && results_seen < 380) ||
                           ($urandom_range(0, 99) >= 14);
            end
        end
    end

    task automatic push_beat(input logic [2:0] cmd, input logic [TIME_W-1:0] now,
                             input logic [ADC_PORT_W-1:0] code);
        cmd_backlog.push_back('{cmd, now, code});
        beats_pushed++;
    endtask

    // Blocks until every queued beat has been accepted and every result has come back.
    // The sender is silent afterwards, as its queue is then empty.
    task automatic wait_drained();
        while (results_seen != beats_pushed)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register write; the model copy follows at once since the block is idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_SAMPLE_PERIOD: cfg_period  = value[PERIOD_W-1:0];
            CFG_GAIN:          cfg_gain    = value[GAIN_W-1:0];
            CFG_OFFSET:        cfg_offset  = value[OFFSET_W-1:0];
            CFG_TRIP_LIMIT:    cfg_trip    = value[TRIP_W-1:0];
            CFG_STARTUP:       cfg_startup = value[PHASE_W-1:0];
            CFG_CALIBRATE:     cfg_calib   = value[PHASE_W-1:0];
            CFG_TIMEOUT:       cfg_timeout = value[TIMEOUT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input int unsigned period, input int unsigned gain,
                            input int unsigned offset, input int unsigned trips,
                            input int unsigned startup, input int unsigned calib,
                            input int unsigned timeout);
        wait_drained();
        write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'(period));
        write_reg(CFG_GAIN,          CFG_DATA_W'(gain));
        write_reg(CFG_OFFSET,        CFG_DATA_W'(offset));
        write_reg(CFG_TRIP_LIMIT,    CFG_DATA_W'(trips));
        write_reg(CFG_STARTUP,       CFG_DATA_W'(startup));
        write_reg(CFG_CALIBRATE,     CFG_DATA_W'(calib));
        write_reg(CFG_TIMEOUT,       CFG_DATA_W'(timeout));
    endtask

    // Random motor runs: each starts the motor and follows with a burst of samples spaced
    // around the sample period, so most runs get through startup and calibration and the
    // current level decides between a trip and a timeout. Speed changes, stops, restarts,
    // early samples, wide clock jumps and unused codes are mixed in as noise.
    task automatic random_runs(input int unsigned target);
        int unsigned           counted;
        int unsigned           burst;
        int unsigned           k;
        int unsigned           pick;
        int unsigned           level;
        logic [ADC_PORT_W-1:0] code;
        counted = 0;
        while (counted < target) begin
            stream_ms += $urandom_range(0, 40);
            push_beat(($urandom_range(0, 3) == 0) ? CMD_REVERSE : CMD_FORWARD, stream_ms,
                      ADC_PORT_W'($urandom));
            counted++;
            level = $urandom_range(0, 4095);
            burst = $urandom_range(4, 30);
            for (k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: code = ADC_PORT_W'(level ^ $urandom_range(0, 127));
                    5, 6, 7:       code = ADC_PORT_W'($urandom_range(2048, 4095));
                    8:             code = ADC_PORT_W'($urandom);
                    default: begin
                        code = '0;
                        if ($urandom_range(0, 1) == 1) code = '1;
                    end
                endcase
                if (pick < 76) begin
                    if (pick < 6) begin
                        stream_ms += $urandom_range(0, cfg_period - 1);
                    end else if (pick < 14) begin
                        stream_ms += cfg_period;
                    end else if (pick < 16) begin
                        stream_ms += $urandom;
                    end else begin
                        stream_ms += cfg_period + $urandom_range(0, cfg_period);
                    end
                    push_beat(CMD_SAMPLE, stream_ms, code);
                    counted++;
                end else if (pick < 84) begin
                    push_beat(($urandom_range(0, 1) == 1) ? CMD_FASTER : CMD_SLOWER,
                              stream_ms + $urandom_range(0, 9), code);
                    counted++;
                end else if (pick < 88) begin
                    push_beat(CMD_STOP, stream_ms + $urandom_range(0, 9), code);
                    counted++;
                end else if (pick < 92) begin
                    push_beat(($urandom_range(0, 1) == 1) ? CMD_SPARE_HI : CMD_SPARE_LO,
                              $urandom, code);
                end else begin
                    stream_ms += $urandom_range(0, 50);
                    push_beat(($urandom_range(0, 1) == 1) ? CMD_FORWARD : CMD_REVERSE,
                              stream_ms, code);
                    counted++;
                end
            end
        end
    endtask

    initial begin : stimulus
        int unsigned ph;
        int unsigned period;
        int unsigned startup;
        int unsigned calib;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset settings. Speed first: up into the top clamp,
        // down into the bottom clamp, then one step back up, all while not driving.
        push_beat(CMD_STOP,   32'd0, 12'd0);
        push_beat(CMD_FASTER, 32'd0, 12'd0);
        push_beat(CMD_FASTER, 32'd0, 12'd0);
        push_beat(CMD_SLOWER, 32'd0, 12'd0);
        push_beat(CMD_SLOWER, 32'd0, 12'd0);
        push_beat(CMD_SLOWER, 32'd0, 12'd0);
        push_beat(CMD_SLOWER, 32'd0, 12'd0);
        push_beat(CMD_FASTER, 32'd0, 12'd0);
        // A sample while off, and the two unused codes with all-ones fields.
        push_beat(CMD_SAMPLE, 32'd5000, 12'd4095);
        push_beat(CMD_SPARE_LO, '1, '1);
        push_beat(CMD_SPARE_HI, '1, '1);
        // Start just below the clock wrap so the run crosses it. Samples: full scale,
        // one too early, one exactly a period later at zero code, then on through
        // startup and calibration into running.
        stream_ms = 32'hFFFF_FF00;
        push_beat(CMD_FORWARD, stream_ms, 12'd0);
        stream_ms += 600;
        push_beat(CMD_SAMPLE, stream_ms, 12'd4095);
        push_beat(CMD_SAMPLE, stream_ms + 100, 12'd4095);
        stream_ms += 500;
        push_beat(CMD_SAMPLE, stream_ms, 12'd0);
        for (ph = 0; ph < 4; ph++) begin
            stream_ms += 600;
            push_beat(CMD_SAMPLE, stream_ms, 12'd1200);
        end
        stream_ms += 500;
        push_beat(CMD_SAMPLE, stream_ms, 12'd4095);
        // Reverse keeps the elapsed time until the next used sample; then stop, and a
        // sample after the stop is ignored.
        stream_ms += 20;
        push_beat(CMD_REVERSE, stream_ms, 12'd0);
        stream_ms += 500;
        push_beat(CMD_SAMPLE, stream_ms, 12'd2047);
        push_beat(CMD_STOP, stream_ms, 12'd0);
        push_beat(CMD_SAMPLE, stream_ms + 1000, 12'd2048);

        // Register extremes: shortest period, full gain and offset, longest trip count,
        // immediate phase changes and the longest timeout.
        set_regs(1, 131071, 1023, 15, 0, 0, 1048575);
        random_runs(70);
        // Longest period and phases, unit gain, zero offset, and a trip limit of zero
        // that stops on the first average above the threshold.
        set_regs(65535, 65536, 0, 0, 65535, 65535, 1048575);
        random_runs(40);
        // Zero gain keeps every current at zero; zero timeout stops on the first run sample.
        set_regs(1, 0, 0, 1, 0, 0, 0);
        random_runs(40);
        // Random settings with the phase times kept a few periods apart.
        for (ph = 0; ph < 3; ph++) begin
            period  = $urandom_range(1, 200);
            startup = period * $urandom_range(0, 6);
            calib   = startup + period * $urandom_range(0, 6);
            set_regs(period, $urandom_range(0, 131071), $urandom_range(0, 1023),
                     $urandom_range(1, 15), startup, calib,
                     calib + period * $urandom_range(0, 40));
            random_runs(100);
        end
        // Back to the reset settings for a last stretch.
        set_regs(PERIOD_RESET, GAIN_RESET, OFFSET_RESET, TRIP_RESET, STARTUP_RESET,
                 CAL_RESET, TIMEOUT_RESET);
        random_runs(50);

        wait_drained();
        $display("Checked %0d result beats: %0d used samples, %0d in running mode,",
                 results_seen, used_seen, running_seen);
        $display("%0d overcurrent or timeout stops, over seven register settings.",
                 supervision_stops);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mcs_pkg.sv
rtl/mcs_avg_window.sv
rtl/motor_current_supervisor_unit.sv
tb/tb_top.sv
